// ----- rtl/bankers_request_safety_check_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the banker's request safety check block.
// Each macro expands to a concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef BANKERS_REQUEST_SAFETY_CHECK_DEFINES_SVH
`define BANKERS_REQUEST_SAFETY_CHECK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BRSC_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BRSC_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define BRSC_ASSERT_IMPL(label, a, c)
`define BRSC_ASSERT_NEXT(label, a, c)
`endif
`endif

// ----- rtl/brsc_pkg.sv -----
// ---------------------------------------------------------------------------
// brsc_pkg
// Commands, status codes and field widths shared by the safety check block.
// ---------------------------------------------------------------------------
package brsc_pkg;
	localparam int AmtW = 8;
	localparam int CmdW = 3;
	localparam int ProcW = 3;
	localparam int StatW = 3;

	localparam logic [CmdW-1:0] CMD_CLAIM = 3'd0;
	localparam logic [CmdW-1:0] CMD_ALLOC = 3'd1;
	localparam logic [CmdW-1:0] CMD_AVAIL = 3'd2;
	localparam logic [CmdW-1:0] CMD_REQ = 3'd3;
	localparam logic [CmdW-1:0] CMD_CHECK = 3'd4;

	localparam logic [StatW-1:0] ST_DONE = 3'd0;
	localparam logic [StatW-1:0] ST_SAFE = 3'd1;
	localparam logic [StatW-1:0] ST_CLAIM = 3'd2;
	localparam logic [StatW-1:0] ST_WAIT = 3'd3;
	localparam logic [StatW-1:0] ST_UNSAFE = 3'd4;
	localparam logic [StatW-1:0] ST_BAD = 3'd5;

	// Result handed from the engine to the output register.
	typedef struct packed {
		logic [StatW-1:0] status;
		logic [ProcW-1:0] seq_process;
		logic last;
	} brsc_res_t;
endpackage

// ----- rtl/brsc_ram.sv -----
// ---------------------------------------------------------------------------
// brsc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module brsc_ram #(
	parameter int Width = 8,
	parameter int Depth = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/brsc_engine.sv -----
// ---------------------------------------------------------------------------
// brsc_engine
// Command sequencer: row loads, request checks and the safety walk over the
// claim and allocation memories, each row a RAM read, then an evaluate.
// ---------------------------------------------------------------------------
module brsc_engine import brsc_pkg::*; #(
	parameter int NumProc = 8,
	parameter int NumRes = 3
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [CmdW-1:0] cmd,
	input logic [ProcW-1:0] process,
	input logic [3*AmtW-1:0] amounts,
	output logic busy,
	output logic res_valid,
	output brsc_res_t res,
	input logic res_ready
);
	localparam int RowW = NumRes * AmtW;
	localparam int PW = (NumProc > 1) ? $clog2(NumProc) : 1;
	localparam int WorkW = AmtW + 4;
	localparam int CntW = $clog2(NumProc + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHKREQ, S_WCLR, S_WRD, S_WEVAL,
		S_URD, S_UNDO, S_EMIT, S_EMRD, S_ONE
	} state_t;

	state_t state_q;
	logic [CmdW-1:0] cmd_q;
	logic [PW-1:0] proc_q;
	logic [RowW-1:0] amt_q;
	logic [AmtW-1:0] avail_q [NumRes];
	logic [WorkW-1:0] work_q [NumRes];
	logic [NumProc-1:0] fin_q;
	logic [PW-1:0] row_q;
	logic [PW-1:0] pass_q;
	logic [CntW-1:0] filled_q;
	logic [StatW-1:0] stat_q;

	// Memory ports.
	logic claim_we, alloc_we, ord_we;
	logic [PW-1:0] claim_wa, alloc_wa, rd_addr, ord_wa, ord_ra;
	logic [RowW-1:0] claim_wd, alloc_wd, claim_rd, alloc_rd;
	logic [ProcW-1:0] ord_wd, ord_rd;

	brsc_ram #(.Width(RowW), .Depth(NumProc)) u_claim (
		.clk, .we(claim_we), .waddr(claim_wa), .wdata(claim_wd),
		.raddr(rd_addr), .rdata(claim_rd));
	brsc_ram #(.Width(RowW), .Depth(NumProc)) u_alloc (
		.clk, .we(alloc_we), .waddr(alloc_wa), .wdata(alloc_wd),
		.raddr(rd_addr), .rdata(alloc_rd));
	brsc_ram #(.Width(ProcW), .Depth(NumProc)) u_order (
		.clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
		.raddr(ord_ra), .rdata(ord_rd));

	// Rows never written since reset read as zero.
	logic [NumProc-1:0] cval_q, aval_q;
	logic [RowW-1:0] claim_row, alloc_row;
	logic rd_valid_c_s1, rd_valid_a_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_c_s1 <= 1'b0;
			rd_valid_a_s1 <= 1'b0;
		end else begin
			rd_valid_c_s1 <= cval_q[rd_addr];
			rd_valid_a_s1 <= aval_q[rd_addr];
		end
	end
	assign claim_row = rd_valid_c_s1 ? claim_rd : '0;
	assign alloc_row = rd_valid_a_s1 ? alloc_rd : '0;

	// Need and fit tests on the row just read.
	logic [AmtW-1:0] need [NumRes];
	logic over_need, over_avail, fits;
	logic [RowW-1:0] alloc_plus, alloc_minus;
	always_comb begin
		over_need = 1'b0;
		over_avail = 1'b0;
		fits = 1'b1;
		for (int r = 0; r < NumRes; r++) begin
			need[r] = (claim_row[r*AmtW +: AmtW] > alloc_row[r*AmtW +: AmtW]) ?
				claim_row[r*AmtW +: AmtW] - alloc_row[r*AmtW +: AmtW] : '0;
			if (amt_q[r*AmtW +: AmtW] > need[r]) over_need = 1'b1;
			if (amt_q[r*AmtW +: AmtW] > avail_q[r]) over_avail = 1'b1;
			if (WorkW'(need[r]) > work_q[r]) fits = 1'b0;
			alloc_plus[r*AmtW +: AmtW] = alloc_row[r*AmtW +: AmtW] + amt_q[r*AmtW +: AmtW];
			alloc_minus[r*AmtW +: AmtW] = alloc_row[r*AmtW +: AmtW] - amt_q[r*AmtW +: AmtW];
		end
	end

	// Memory control decoded from the state.
	always_comb begin
		claim_we = 1'b0;
		alloc_we = 1'b0;
		claim_wa = proc_q;
		alloc_wa = proc_q;
		claim_wd = amt_q;
		alloc_wd = amt_q;
		rd_addr = (state_q == S_WRD || state_q == S_WEVAL) ? row_q : proc_q;
		ord_we = 1'b0;
		ord_wa = filled_q[PW-1:0];
		ord_wd = ProcW'(row_q);
		ord_ra = row_q;
		unique case (state_q)
			S_IDLE: begin
				claim_we = start && cmd == CMD_CLAIM && 32'(process) < NumProc;
				alloc_we = start && cmd == CMD_ALLOC && 32'(process) < NumProc;
				claim_wa = PW'(process);
				alloc_wa = PW'(process);
				claim_wd = amounts[RowW-1:0];
				alloc_wd = amounts[RowW-1:0];
				rd_addr = PW'(process);
			end
			S_CHKREQ: begin
				alloc_we = !over_need && !over_avail;
				alloc_wd = alloc_plus;
			end
			S_WEVAL: ord_we = !fin_q[row_q] && fits;
			S_UNDO: begin
				alloc_we = 1'b1;
				alloc_wd = alloc_minus;
			end
			default: ;
		endcase
	end

	logic out_full;
	assign res_valid = out_full;
	assign busy = (state_q != S_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cval_q <= '0;
			aval_q <= '0;
			fin_q <= '0;
			out_full <= 1'b0;
			filled_q <= '0;
			row_q <= '0;
			pass_q <= '0;
			for (int r = 0; r < NumRes; r++) begin
				avail_q[r] <= '0;
				work_q[r] <= '0;
			end
		end else begin
			if (out_full && res_ready) out_full <= 1'b0;
			if (claim_we) cval_q[claim_wa] <= 1'b1;
			if (alloc_we) aval_q[alloc_wa] <= 1'b1;
			unique case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					proc_q <= PW'(process);
					amt_q <= amounts[RowW-1:0];
					if (cmd > CMD_CHECK ||
							((cmd == CMD_CLAIM || cmd == CMD_ALLOC || cmd == CMD_REQ) &&
							32'(process) >= NumProc)) begin
						stat_q <= ST_BAD;
						state_q <= S_ONE;
					end else if (cmd == CMD_REQ) begin
						state_q <= S_RD;
					end else if (cmd == CMD_CHECK) begin
						state_q <= S_WCLR;
					end else begin
						if (cmd == CMD_AVAIL)
							for (int r = 0; r < NumRes; r++)
								avail_q[r] <= amounts[r*AmtW +: AmtW];
						stat_q <= ST_DONE;
						state_q <= S_ONE;
					end
				end
				S_RD: state_q <= S_CHKREQ;
				S_CHKREQ: begin
					if (over_need) begin
						stat_q <= ST_CLAIM;
						state_q <= S_ONE;
					end else if (over_avail) begin
						stat_q <= ST_WAIT;
						state_q <= S_ONE;
					end else begin
						for (int r = 0; r < NumRes; r++)
							avail_q[r] <= avail_q[r] - amt_q[r*AmtW +: AmtW];
						state_q <= S_WCLR;
					end
				end
				S_WCLR: begin
					fin_q <= '0;
					filled_q <= '0;
					row_q <= '0;
					pass_q <= '0;
					for (int r = 0; r < NumRes; r++) work_q[r] <= WorkW'(avail_q[r]);
					state_q <= S_WRD;
				end
				S_WRD: state_q <= S_WEVAL;
				S_WEVAL: begin
					if (!fin_q[row_q] && fits) begin
						for (int r = 0; r < NumRes; r++)
							work_q[r] <= work_q[r] + WorkW'(alloc_row[r*AmtW +: AmtW]);
						fin_q[row_q] <= 1'b1;
						filled_q <= filled_q + 1'b1;
					end
					if (32'(row_q) == NumProc - 1) begin
						row_q <= '0;
						if (32'(pass_q) == NumProc - 1) begin
							if (32'(filled_q) + ((!fin_q[row_q] && fits) ? 1 : 0) == NumProc) begin
								state_q <= S_EMRD;
							end else begin
								stat_q <= ST_UNSAFE;
								state_q <= (cmd_q == CMD_REQ) ? S_URD : S_ONE;
							end
						end else begin
							pass_q <= pass_q + 1'b1;
							state_q <= S_WRD;
						end
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				// Read the requesting row again before the rollback.
				S_URD: state_q <= S_UNDO;
				S_UNDO: begin
					for (int r = 0; r < NumRes; r++)
						avail_q[r] <= avail_q[r] + amt_q[r*AmtW +: AmtW];
					state_q <= S_ONE;
				end
				S_EMRD: state_q <= S_EMIT;
				S_EMIT: if (!out_full) begin
					res <= '{status: ST_SAFE, seq_process: ord_rd,
						last: (32'(row_q) == NumProc - 1)};
					out_full <= 1'b1;
					if (32'(row_q) == NumProc - 1) begin
						state_q <= S_IDLE;
						row_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= S_EMRD;
					end
				end
				S_ONE: if (!out_full) begin
					res <= '{status: stat_q, seq_process: '0, last: 1'b1};
					out_full <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/bankers_request_safety_check.sv -----
// ---------------------------------------------------------------------------
// bankers_request_safety_check
// Banker's deadlock-avoidance engine: claim and allocation rows in RAM,
// request checks and a safety walk that emits the safe sequence.
//
// Channel  Dir  tdata (low bit first)                     tuser
// s_axis   in   cmd, process, amount_r0..r2 (32 bits)      -
// m_axis   out  status, seq_process (8 bits)               -   (tlast=last)
//
// A request or check walks NumProc passes of NumProc rows, each row a RAM
// read, then an evaluate. One request is handled at a time; the output
// register holds a result until taken, which stalls the sequencer.
// Reset clears the control state and the available vector; rows never
// written read as zero through per-row valid flags.
// ---------------------------------------------------------------------------
module bankers_request_safety_check import brsc_pkg::*; #(
	parameter int NUM_PROCESSES = 8,
	parameter int NUM_RESOURCES = 3
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // cmd, process, amount_r0, amount_r1, amount_r2
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // status, seq_process, zero pad
	output logic m_axis_tlast
);
	`include "bankers_request_safety_check_defines.svh"

	logic busy;
	logic start;
	brsc_res_t res;

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;

	brsc_engine #(.NumProc(NUM_PROCESSES), .NumRes(NUM_RESOURCES)) u_engine (
		.clk, .arst_n, .start,
		.cmd(s_axis_tdata[2:0]),
		.process(s_axis_tdata[5:3]),
		.amounts(s_axis_tdata[29:6]),
		.busy,
		.res_valid(m_axis_tvalid),
		.res,
		.res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {2'b00, res.seq_process, res.status};
	assign m_axis_tlast = res.last;

	`BRSC_ASSERT_NEXT(a_busy_after_start, start, !s_axis_tready)
	`BRSC_ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= ST_BAD)
	`BRSC_ASSERT_IMPL(a_seq_only_safe, m_axis_tvalid && m_axis_tdata[2:0] != ST_SAFE,
		m_axis_tlast && m_axis_tdata[5:3] == 3'd0)
endmodule

// ----- tb/bankers_request_safety_check_tb.sv -----
// ---------------------------------------------------------------------------
// Banker's request safety check testbench
// Drives commands over the input stream, predicts every result with an
// independent model of the claim, allocation and available tables, and
// compares each returned result, in order, against the prediction.
// ---------------------------------------------------------------------------
module bankers_request_safety_check_tb;
	import brsc_pkg::*;

	localparam int NP = 8;
	localparam int NR = 3;
	localparam int LIMIT = 2000000;

	// Expected result of one command output beat.
	typedef struct {
		logic [StatW-1:0] status;
		logic [ProcW-1:0] seq_process;
		logic last;
	} bank_res_t;

	// Scoreboard: holds the table copies and the queue of expected results.
	class bank_scoreboard;
		bit [AmtW-1:0] claim[NP][NR];
		bit [AmtW-1:0] alloc[NP][NR];
		bit [AmtW-1:0] avail[NR];
		bank_res_t pending[$];
		int errors;

		function void push_one(logic [StatW-1:0] st);
			bank_res_t r;
			r.status = st;
			r.seq_process = '0;
			r.last = 1'b1;
			pending.push_back(r);
		endfunction

		function int unsigned need(int p, int r);
			return (claim[p][r] > alloc[p][r]) ? claim[p][r] - alloc[p][r] : 0;
		endfunction

		// Safety walk; on success pushes the safe sequence.
		function bit walk_and_emit();
			int unsigned work[NR];
			bit done_row[NP];
			int order[NP];
			int filled;
			bit fits;
			bank_res_t r;
			filled = 0;
			for (int i = 0; i < NR; i++) work[i] = avail[i];
			for (int p = 0; p < NP; p++) done_row[p] = 0;
			for (int pass = 0; pass < NP; pass++) begin
				for (int p = 0; p < NP; p++) begin
					if (done_row[p]) continue;
					fits = 1;
					for (int i = 0; i < NR; i++) if (need(p, i) > work[i]) fits = 0;
					if (!fits) continue;
					for (int i = 0; i < NR; i++) work[i] += alloc[p][i];
					done_row[p] = 1;
					order[filled] = p;
					filled++;
				end
			end
			if (filled != NP) return 0;
			for (int k = 0; k < NP; k++) begin
				r.status = ST_SAFE;
				r.seq_process = ProcW'(order[k]);
				r.last = (k == NP - 1);
				pending.push_back(r);
			end
			return 1;
		endfunction

		// Note one accepted request and predict its results.
		function void note_request(logic [31:0] d);
			logic [CmdW-1:0] cmd;
			int p;
			bit [AmtW-1:0] amt[NR];
			bit rejected;
			cmd = d[2:0];
			p = d[5:3];
			amt[0] = d[13:6];
			amt[1] = d[21:14];
			amt[2] = d[29:22];
			case (cmd)
				CMD_CLAIM: begin
					for (int i = 0; i < NR; i++) claim[p][i] = amt[i];
					push_one(ST_DONE);
				end
				CMD_ALLOC: begin
					for (int i = 0; i < NR; i++) alloc[p][i] = amt[i];
					push_one(ST_DONE);
				end
				CMD_AVAIL: begin
					for (int i = 0; i < NR; i++) avail[i] = amt[i];
					push_one(ST_DONE);
				end
				CMD_REQ: begin
					rejected = 0;
					for (int i = 0; i < NR; i++) if (amt[i] > need(p, i)) rejected = 1;
					if (rejected) push_one(ST_CLAIM);
					else begin
						for (int i = 0; i < NR; i++) if (amt[i] > avail[i]) rejected = 1;
						if (rejected) push_one(ST_WAIT);
						else begin
							for (int i = 0; i < NR; i++) begin
								avail[i] -= amt[i];
								alloc[p][i] += amt[i];
							end
							if (!walk_and_emit()) begin
								for (int i = 0; i < NR; i++) begin
									avail[i] += amt[i];
									alloc[p][i] -= amt[i];
								end
								push_one(ST_UNSAFE);
							end
						end
					end
				end
				CMD_CHECK: if (!walk_and_emit()) push_one(ST_UNSAFE);
				default: push_one(ST_BAD);
			endcase
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [7:0] d, logic lst);
			bank_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d", d[2:0]);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[2:0] !== e.status) begin
				$error("status expected %0d actual %0d", e.status, d[2:0]);
				errors++;
			end
			if (d[5:3] !== e.seq_process) begin
				$error("seq_process expected %0d actual %0d", e.seq_process, d[5:3]);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last expected %0d actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [7:0] m_axis_tdata;
	logic m_axis_tlast;

	bank_scoreboard sb;
	int cycles = 0;
	int hold_off = 0;
	bit stim_done = 0;

	bankers_request_safety_check dut (.*);

	always #5 clk = ~clk;

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: a drawn wait after each result, plus one long hold-off.
	initial begin
		int wait_n;
		wait_n = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tlast);
				wait_n = $urandom_range(0, 10);
			end
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 0;
			end else if (wait_n > 0) begin
				wait_n--;
				m_axis_tready <= 0;
			end else m_axis_tready <= 1;
		end
	end

	// Send one command and note it once accepted. Valid stays high after
	// acceptance so that a following command can go out back to back.
	task automatic send_cmd(logic [CmdW-1:0] cmd, logic [2:0] p,
			logic [7:0] a0, logic [7:0] a1, logic [7:0] a2, bit idle_ok);
		int gap;
		gap = idle_ok ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {2'b00, a2, a1, a0, p, cmd};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(s_axis_tdata);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Random command biased toward meaningful tables and fitting requests.
	task automatic send_random(bit idle_ok);
		int k;
		logic [CmdW-1:0] c;
		logic [2:0] p;
		logic [7:0] a[3];
		k = $urandom_range(0, 99);
		p = 3'($urandom_range(0, NP - 1));
		for (int i = 0; i < 3; i++) a[i] = 8'($urandom_range(0, 15));
		if (k < 12) c = CMD_CLAIM;
		else if (k < 22) c = CMD_ALLOC;
		else if (k < 30) c = CMD_AVAIL;
		else if (k < 75) begin
			c = CMD_REQ;
			for (int i = 0; i < 3; i++) begin
				int unsigned n;
				n = sb.need(p, i);
				if ($urandom_range(0, 4) != 0)
					a[i] = 8'($urandom_range(0, n < 255 ? n : 255));
			end
		end else if (k < 92) c = CMD_CHECK;
		else c = CmdW'($urandom_range(5, 7));
		if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) a[i] = 8'($urandom);
		send_cmd(c, p, a[0], a[1], a[2], idle_ok);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: check on empty tables, loads at extremes, all outcomes but unsafe.
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0);
		send_cmd(CMD_AVAIL, 0, 8'hFF, 8'hFF, 8'hFF, 0);
		send_cmd(CMD_CLAIM, 7, 8'hFF, 8'hFF, 8'hFF, 0);
		send_cmd(CMD_ALLOC, 7, 8'hFF, 8'hFF, 8'hFF, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0);
		send_cmd(CMD_CLAIM, 0, 10, 5, 7, 0);
		send_cmd(CMD_ALLOC, 0, 12, 0, 0, 0);   // allocation above claim
		send_cmd(CMD_REQ, 0, 0, 6, 0, 0);      // over need
		send_cmd(CMD_AVAIL, 0, 2, 2, 2, 0);
		send_cmd(CMD_REQ, 0, 0, 3, 0, 0);      // over available
		send_cmd(CMD_REQ, 0, 0, 2, 2, 0);      // granted, safe
		send_cmd(CMD_CLAIM, 1, 200, 0, 0, 0);
		send_cmd(CMD_ALLOC, 1, 0, 0, 0, 0);
		send_cmd(CMD_AVAIL, 0, 0, 0, 0, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0);    // check with nothing available, safe
		send_cmd(CMD_AVAIL, 0, 5, 0, 0, 0);
		send_cmd(CMD_REQ, 1, 5, 0, 0, 0);      // request granted, safe
		send_cmd(5, 0, 0, 0, 0, 0);
		send_cmd(7, 7, 8'hFF, 8'hFF, 8'hFF, 0);
		send_cmd(CMD_ALLOC, 1, 8'hFF, 8'hFF, 8'hFF, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0);
		// Reset tables to something walkable.
		for (int p = 0; p < NP; p++) begin
			send_cmd(CMD_CLAIM, 3'(p), 8'($urandom_range(0, 12)),
				8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)), 0);
			send_cmd(CMD_ALLOC, 3'(p), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 0);
		end
		send_cmd(CMD_AVAIL, 0, 20, 20, 20, 0);
		// Receiver holds off while the sender keeps offering.
		hold_off = 400;
		for (int n = 0; n < 20; n++) send_random(0);
		// Sender pauses until everything is back.
		drain();
		for (int n = 0; n < 480; n++) begin
			send_random(n < 200 || n > 350);
			if (n % 60 == 0 && $urandom_range(0, 1)) send_cmd(CMD_AVAIL, 0,
				8'($urandom_range(8, 40)), 8'($urandom_range(8, 40)),
				8'($urandom_range(8, 40)), 1);
		end
		drain();
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
